@@ design/htsb_pkg.sv @@
// package: constants and types for the sorted-bucket hash table
`timescale 1ns / 1ps
`default_nettype none
package htsb_pkg;
    localparam int NumBuckets  = 64;
    localparam int BucketDepth = 16;
    localparam int WordWidth   = 32;

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_FIND = 2'd1,
        MODE_FDEL = 2'd2,
        MODE_DELP = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    localparam logic CFG_KEY_MASK = 1'b0;
    localparam logic CFG_SIGNED   = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  bucket;
        logic [31:0] key_word;
        logic [3:0]  position;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [31:0] entry_word;
        logic [1:0]  status;
        logic [10:0] total_count;
    } t_rsp;
endpackage
`default_nettype wire

@@ design/htsb_if.sv @@
// interface: valid/ready channel carrying one payload struct
`timescale 1ns / 1ps
`default_nettype none
interface htsb_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/htsb_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module htsb_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ design/hash_table_sorted_buckets.sv @@
// top level: hash table of sorted buckets held in one entry ram
//
//  channel | dir | payload
//  i_req   | in  | mode, bucket, key_word, position
//  o_rsp   | out | found, entry_word, status, total_count
//  config  | in  | i_cfg_we, i_cfg_index, i_cfg_data
//
// each compare passes through a read state and a compare state, and each entry moved
// is read from the entry ram and then written back one place along.
// synchronous reset clears the total and starts a clearing pass over every bucket
// of the fill ram; no request beat is taken during it.
// a new request beat is taken in the idle state once the result register is free.
`timescale 1ns / 1ps
`default_nettype none
module hash_table_sorted_buckets
    import htsb_pkg::*;
#(
    parameter int NUM_BUCKETS  = NumBuckets,
    parameter int BUCKET_DEPTH = BucketDepth,
    parameter int WORD_WIDTH   = WordWidth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    htsb_if.sink             i_req,
    htsb_if.source           o_rsp
);
    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int PW = $clog2(BUCKET_DEPTH);
    localparam int FW = $clog2(BUCKET_DEPTH + 1);
    localparam int AW = BW + PW;
    localparam int CW = 11;

    typedef enum logic [7:0] {
        S_CLR   = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_FILL  = 8'b00000100,
        S_RD    = 8'b00001000,
        S_CMP   = 8'b00010000,
        S_INS   = 8'b00100000,
        S_DEL   = 8'b01000000,
        S_DONE  = 8'b10000000
    } t_state;

    t_state              r_state;
    logic [31:0]         r_mask;
    logic                r_sgn;
    logic [BW-1:0]       r_clr;
    logic [CW-1:0]       r_total;
    logic [1:0]          r_mode;
    logic [BW-1:0]       r_bkt;
    logic [WORD_WIDTH-1:0] r_key;
    logic [PW:0]         r_idx;
    logic [FW-1:0]       r_n;
    logic [PW:0]         r_pos;
    logic                r_rdpend;
    logic                r_ovalid;
    t_rsp                r_rsp;

    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;

    logic                fill_we;
    logic [BW-1:0]       fill_addr;
    logic [FW-1:0]       fill_wdata, fill_rdata;

    htsb_ram #(.Width(WORD_WIDTH), .Depth(2 ** AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    htsb_ram #(.Width(FW), .Depth(2 ** BW)) u_fill (
        .i_clk  (i_clk),
        .i_we   (fill_we),
        .i_addr (fill_addr),
        .i_wdata(fill_wdata),
        .o_rdata(fill_rdata)
    );

    // masked compare of stored word against the key
    logic [WORD_WIDTH-1:0] mword, ma, mb;
    logic gt, eq;
    always_comb begin
        mword = WORD_WIDTH'({{(WORD_WIDTH > 32 ? WORD_WIDTH - 32 : 1){1'b0}}, r_mask});
        ma = ram_rdata & mword;
        mb = r_key & mword;
        if (r_sgn) begin
            ma[WORD_WIDTH-1] = ~ma[WORD_WIDTH-1];
            mb[WORD_WIDTH-1] = ~mb[WORD_WIDTH-1];
        end
        gt = ma > mb;
        eq = ma == mb;
    end

    function automatic logic [AW-1:0] addr_of(input logic [BW-1:0] b, input logic [PW:0] i);
        return {b, i[PW-1:0]};
    endfunction

    assign i_req.ready   = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.data    = r_rsp;

    logic [PW:0] n_ext;
    assign n_ext = (PW + 1)'(r_n);

    always_comb begin
        ram_we     = 1'b0;
        ram_addr   = addr_of(r_bkt, r_idx);
        ram_wdata  = ram_rdata;
        fill_we    = 1'b0;
        fill_addr  = r_bkt;
        fill_wdata = r_n;
        case (r_state)
            S_CLR: begin
                fill_we    = 1'b1;
                fill_addr  = r_clr;
                fill_wdata = '0;
            end
            S_IDLE: begin
                fill_addr = BW'(i_req.data.bucket);
            end
            S_INS: begin
                // shift down: read idx-1 then write idx
                if (r_rdpend) begin
                    ram_we = 1'b1;
                end else if (r_idx != r_pos) begin
                    ram_addr = addr_of(r_bkt, r_idx - 1'b1);
                end else begin
                    ram_we     = 1'b1;
                    ram_wdata  = r_key;
                    fill_we    = 1'b1;
                    fill_wdata = r_n + 1'b1;
                end
            end
            S_DEL: begin
                if (r_rdpend) begin
                    ram_we = 1'b1;
                end else if (r_idx + 1'b1 < n_ext) begin
                    ram_addr = addr_of(r_bkt, r_idx + 1'b1);
                end else begin
                    fill_we    = 1'b1;
                    fill_wdata = r_n - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_mask   <= '1;
            r_sgn    <= 1'b0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
            r_rdpend <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_KEY_MASK) r_mask <= i_cfg_data;
                else r_sgn <= i_cfg_data[0];
            end
            if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == BW'(NUM_BUCKETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_mode <= i_req.data.mode;
                        r_bkt  <= BW'(i_req.data.bucket);
                        r_key  <= WORD_WIDTH'(i_req.data.key_word);
                        r_pos  <= (PW + 1)'(i_req.data.position);
                        r_idx  <= (i_req.data.mode == MODE_DELP) ?
                                  (PW + 1)'(i_req.data.position) : '0;
                        r_rdpend <= 1'b0;
                        r_rsp  <= '{found: 1'b0, entry_word: '0,
                                   status: ST_MISS, total_count: r_total};
                        if (32'(i_req.data.bucket) >= 32'(NUM_BUCKETS)) r_state <= S_DONE;
                        else r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_n     <= fill_rdata;
                    r_state <= S_RD;
                end
                S_RD: begin
                    // issue read of r_idx or decide
                    if (r_mode == MODE_DELP) begin
                        if (r_pos < n_ext) begin
                            r_idx   <= r_pos;
                            r_rdpend <= 1'b1;
                            r_state <= S_CMP;
                        end else r_state <= S_DONE;
                    end else if (r_mode == MODE_ADD && n_ext == (PW + 1)'(BUCKET_DEPTH)) begin
                        r_rsp.status <= ST_FULL;
                        r_state <= S_DONE;
                    end else if (r_idx >= n_ext) begin
                        if (r_mode == MODE_ADD) begin
                            r_pos <= r_idx;
                            r_idx <= n_ext;
                            r_rdpend <= 1'b0;
                            r_state <= S_INS;
                        end else r_state <= S_DONE;
                    end else r_state <= S_CMP;
                end
                S_CMP: begin
                    r_rdpend <= 1'b0;
                    if (r_mode == MODE_DELP || (r_mode != MODE_ADD && eq)) begin
                        r_rsp.found      <= 1'b1;
                        r_rsp.entry_word <= 32'(ram_rdata);
                        r_rsp.status     <= ST_OK;
                        if (r_mode == MODE_FIND) r_state <= S_DONE;
                        else r_state <= S_DEL;
                    end else if (r_mode == MODE_ADD && gt) begin
                        r_pos <= r_idx;
                        r_idx <= n_ext;
                        r_state <= S_INS;
                    end else if (r_mode == MODE_FDEL && gt) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_INS: begin
                    if (r_rdpend) begin
                        r_rdpend <= 1'b0;
                        r_idx <= r_idx - 1'b1;
                    end else if (r_idx != r_pos) begin
                        r_rdpend <= 1'b1;
                    end else begin
                        r_total <= r_total + 1'b1;
                        r_rsp.total_count <= r_total + 1'b1;
                        r_rsp.status <= ST_OK;
                        r_state <= S_DONE;
                    end
                end
                S_DEL: begin
                    if (r_rdpend) begin
                        r_rdpend <= 1'b0;
                        r_idx <= r_idx + 1'b1;
                    end else if (r_idx + 1'b1 < n_ext) begin
                        r_rdpend <= 1'b1;
                    end else begin
                        r_total <= r_total - 1'b1;
                        r_rsp.total_count <= r_total - 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
